@@ rtl/ddp_pkg.sv @@
// Shared widths, types and constants for the drive-distance profile block.
`timescale 1ns / 1ps

package ddp_pkg;

  // Field widths fixed by the interface definition
  localparam int KIND_W   = 2;
  localparam int VEL_W    = 16;
  localparam int REM_W    = 24;
  localparam int TGT_W    = 24;
  localparam int SPEED_W  = 15;
  localparam int DECEL_W  = 16;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  // Serial arithmetic unit widths
  localparam int MUL_W    = 32;                 // operand width of the shift-add multiplier
  localparam int PROD_W   = 2 * MUL_W;          // product / radicand width
  localparam int ROOT_W   = PROD_W / 2;         // square root result width
  localparam int STEP_W   = 5;                  // step counter, 32 steps per operation

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ENC   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL     = 2'd3;

  // Input transaction kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ rtl/ddp_if.sv @@
// Valid/ready channel interfaces for pose transactions and velocity commands.
`timescale 1ns / 1ps

interface ddp_in_if #(
  parameter int POS_BITS = 24
);
  logic                                valid;
  logic                                ready;
  logic [ddp_pkg::KIND_W-1:0]          kind;
  logic signed [POS_BITS-1:0]          enc_x;
  logic signed [POS_BITS-1:0]          enc_y;
  logic signed [POS_BITS-1:0]          odo_x;
  logic signed [POS_BITS-1:0]          odo_y;
  logic signed [ddp_pkg::VEL_W-1:0]    measured_vel;

  modport source (
    output valid, kind, enc_x, enc_y, odo_x, odo_y, measured_vel,
    input  ready
  );
  modport sink (
    input  valid, kind, enc_x, enc_y, odo_x, odo_y, measured_vel,
    output ready
  );
endinterface

interface ddp_out_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd_valid;
  logic signed [ddp_pkg::VEL_W-1:0]    cmd_vel;
  logic                                achieved;
  logic signed [ddp_pkg::REM_W-1:0]    remaining;

  modport source (
    output valid, cmd_valid, cmd_vel, achieved, remaining,
    input  ready
  );
  modport sink (
    input  valid, cmd_valid, cmd_vel, achieved, remaining,
    output ready
  );
endinterface

@@ rtl/drive_distance_decel_profile.sv @@
// Drive-distance controller with a square-root braking velocity profile.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------------
//  in_i     | in  | valid / ready    | kind, enc_x, enc_y, odo_x, odo_y, measured_vel
//  out_o    | out | valid / ready    | cmd_valid, cmd_vel, achieved, remaining
//  cfg      | in  | cfg_we_i         | cfg_idx_i, cfg_data_i (write only)
//
// One transaction in flight; in_i takes the next transaction once the result of the last
// one is in the output register. Start, cancel, unused kinds and non-moving ticks go straight to it.
// A moving tick runs two 32-step serial multiplies and two 32-step serial roots;
// a huge step skips the first multiply/root pair, a tick at or past the target the second.
// Reset (async, active low) clears mode, pose, travelled distance and restores registers.
// A result waiting in the output register holds the next one back and stalls in_i.
`timescale 1ns / 1ps

module drive_distance_decel_profile #(
  parameter int POS_BITS  = 24,
  parameter int FRAC_BITS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ddp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ddp_pkg::CFG_W-1:0]         cfg_data_i,
  ddp_in_if.sink                            in_i,
  ddp_out_if.source                         out_o
);

  localparam int AXF_W    = (POS_BITS + FRAC_BITS > 32) ? POS_BITS + FRAC_BITS : 32;
  localparam int TRAV_W   = 32;
  localparam int REMFX_W  = TRAV_W + 2;
  localparam int HUGE_BIT = 31;
  localparam logic signed [ddp_pkg::VEL_W-1:0] STOP_VEL = 16'sd5;
  localparam logic signed [REMFX_W-1:0] REM_HI = REMFX_W'(8388607);
  localparam logic signed [REMFX_W-1:0] REM_LO = -REMFX_W'(8388608);

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_GOING    = 2'd1,
    MODE_ACHIEVED = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQ, S_ROOT1, S_ACCUM, S_REM, S_PROD, S_ROOT2, S_PUT
  } state_e;

  // ---------------------------------------------------------------------------
  // configuration registers
  logic signed [ddp_pkg::TGT_W-1:0]   target_q;
  logic                               use_enc_q;
  logic [ddp_pkg::SPEED_W-1:0]        max_speed_q;
  logic [ddp_pkg::DECEL_W-1:0]        decel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      use_enc_q   <= 1'b1;
      max_speed_q <= 15'd400;
      decel_q     <= 16'd200;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ddp_pkg::CFG_TARGET:    target_q    <= cfg_data_i[ddp_pkg::TGT_W-1:0];
        ddp_pkg::CFG_USE_ENC:   use_enc_q   <= cfg_data_i[0];
        ddp_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_data_i[ddp_pkg::SPEED_W-1:0];
        ddp_pkg::CFG_DECEL:     decel_q     <= cfg_data_i[ddp_pkg::DECEL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shared serial units
  logic                           mul_start_q, sqrt_start_q;
  logic [ddp_pkg::MUL_W-1:0]      mul_a_q, mul_ma_q, mul_b_q, mul_mb_q;
  logic [ddp_pkg::PROD_W-1:0]     sqrt_rad_q;
  logic [ddp_pkg::PROD_W-1:0]     prod;
  logic [ddp_pkg::ROOT_W-1:0]     root;
  ddp_pkg::unit_stat_t            mul_stat, sqrt_stat;

  ddp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .ma_i    (mul_ma_q),
    .b_i     (mul_b_q),
    .mb_i    (mul_mb_q),
    .prod_o  (prod),
    .stat_o  (mul_stat)
  );

  ddp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_q),
    .rad_i   (sqrt_rad_q),
    .root_o  (root),
    .stat_o  (sqrt_stat)
  );

  // ---------------------------------------------------------------------------
  // state and datapath registers
  state_e                         state_q;
  mode_e                          mode_q;
  logic signed [POS_BITS-1:0]     last_x_q, last_y_q, px_q, py_q;
  logic signed [ddp_pkg::VEL_W-1:0] mvel_q;
  logic [TRAV_W-1:0]              travelled_q, step_q;
  logic                           res_cmd_q, res_ach_q;
  logic signed [ddp_pkg::VEL_W-1:0] res_vel_q;
  logic signed [ddp_pkg::REM_W-1:0] res_rem_q;
  logic                           out_valid_q, out_cmd_q, out_ach_q;
  logic signed [ddp_pkg::VEL_W-1:0] out_vel_q;
  logic signed [ddp_pkg::REM_W-1:0] out_rem_q;

  // pose of the selected source at the input
  logic signed [POS_BITS-1:0] in_px, in_py;
  assign in_px = use_enc_q ? in_i.enc_x : in_i.odo_x;
  assign in_py = use_enc_q ? in_i.enc_y : in_i.odo_y;

  // absolute step per axis, scaled to fixed point
  logic signed [POS_BITS:0]   diff_x, diff_y;
  logic [POS_BITS-1:0]        dx, dy;
  logic [AXF_W-1:0]           ax_full, ay_full;
  logic                       huge;

  always_comb begin
    diff_x  = {px_q[POS_BITS-1], px_q} - {last_x_q[POS_BITS-1], last_x_q};
    diff_y  = {py_q[POS_BITS-1], py_q} - {last_y_q[POS_BITS-1], last_y_q};
    dx      = diff_x[POS_BITS] ? POS_BITS'(-diff_x) : diff_x[POS_BITS-1:0];
    dy      = diff_y[POS_BITS] ? POS_BITS'(-diff_y) : diff_y[POS_BITS-1:0];
    ax_full = AXF_W'(dx) << FRAC_BITS;
    ay_full = AXF_W'(dy) << FRAC_BITS;
    huge    = (|ax_full[AXF_W-1:HUGE_BIT]) || (|ay_full[AXF_W-1:HUGE_BIT]);
  end

  // travelled distance update, saturating
  logic [TRAV_W:0]   trav_sum;
  logic [TRAV_W-1:0] trav_next;
  assign trav_sum  = {1'b0, travelled_q} + {1'b0, step_q};
  assign trav_next = trav_sum[TRAV_W] ? '1 : trav_sum[TRAV_W-1:0];

  // remaining distance in fixed point and whole mm (floor, saturated)
  logic [ddp_pkg::TGT_W-1:0]     mag;
  logic [TRAV_W-1:0]             mag_fx;
  logic signed [REMFX_W-1:0]     rem_fx, rem_floor;
  logic signed [ddp_pkg::REM_W-1:0] rem_mm;
  logic                          rem_pos;

  always_comb begin
    mag       = target_q[ddp_pkg::TGT_W-1] ? ddp_pkg::TGT_W'(-target_q) : target_q;
    mag_fx    = TRAV_W'(mag) << FRAC_BITS;
    rem_fx    = $signed({2'b00, mag_fx}) - $signed({2'b00, travelled_q});
    rem_pos   = !rem_fx[REMFX_W-1] && (|rem_fx);
    rem_floor = rem_fx >>> FRAC_BITS;
    if (rem_floor > REM_HI) begin
      rem_mm = REM_HI[ddp_pkg::REM_W-1:0];
    end else if (rem_floor < REM_LO) begin
      rem_mm = REM_LO[ddp_pkg::REM_W-1:0];
    end else begin
      rem_mm = rem_floor[ddp_pkg::REM_W-1:0];
    end
  end

  // velocity from the braking root, capped and signed
  logic [ddp_pkg::ROOT_W-1:0] v_full, v_cap;
  logic [ddp_pkg::VEL_W-1:0]  v16;
  logic signed [ddp_pkg::VEL_W-1:0] vel;
  logic                       slow;

  always_comb begin
    v_full = root >> FRAC_BITS;
    v_cap  = (v_full > ddp_pkg::ROOT_W'(max_speed_q)) ? ddp_pkg::ROOT_W'(max_speed_q) : v_full;
    v16    = v_cap[ddp_pkg::VEL_W-1:0];
    vel    = target_q[ddp_pkg::TGT_W-1] ? $signed(~v16 + 1'b1) : $signed(v16);
    slow   = (mvel_q > -STOP_VEL) && (mvel_q < STOP_VEL);
  end

  logic out_take, out_load;
  assign out_take = out_valid_q && out_o.ready;
  assign out_load = (state_q == S_PUT) && (!out_valid_q || out_o.ready);

  // control sequence and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_IDLE;
      last_x_q     <= '0;
      last_y_q     <= '0;
      px_q         <= '0;
      py_q         <= '0;
      mvel_q       <= '0;
      travelled_q  <= '0;
      step_q       <= '0;
      mul_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      mul_a_q      <= '0;
      mul_ma_q     <= '0;
      mul_b_q      <= '0;
      mul_mb_q     <= '0;
      sqrt_rad_q   <= '0;
      res_cmd_q    <= 1'b0;
      res_ach_q    <= 1'b0;
      res_vel_q    <= '0;
      res_rem_q    <= '0;
      out_valid_q  <= 1'b0;
      out_cmd_q    <= 1'b0;
      out_ach_q    <= 1'b0;
      out_vel_q    <= '0;
      out_rem_q    <= '0;
    end else begin
      // serial units start in the cycle after their operands are chosen
      mul_start_q  <= ((state_q == S_DIFF) && !huge) || ((state_q == S_REM) && rem_pos);
      sqrt_start_q <= ((state_q == S_SQ) || (state_q == S_PROD)) && mul_stat.done;
      // output register: load a finished result, or empty once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            px_q      <= in_px;
            py_q      <= in_py;
            mvel_q    <= in_i.measured_vel;
            res_cmd_q <= 1'b0;
            res_vel_q <= '0;
            res_rem_q <= '0;
            // achieved flag shows the mode left by this transaction
            res_ach_q <= (mode_q == MODE_ACHIEVED) &&
                         !(in_i.kind inside {ddp_pkg::KIND_START, ddp_pkg::KIND_CANCEL});
            state_q   <= (in_i.kind == ddp_pkg::KIND_TICK && mode_q == MODE_GOING) ?
                         S_DIFF : S_PUT;
            case (in_i.kind)
              ddp_pkg::KIND_START: begin
                mode_q      <= MODE_GOING;
                last_x_q    <= in_px;
                last_y_q    <= in_py;
                travelled_q <= '0;
              end
              ddp_pkg::KIND_CANCEL: begin
                mode_q <= MODE_IDLE;
              end
              default: ;
            endcase
          end
        end
        S_DIFF: begin
          if (huge) begin
            step_q  <= TRAV_W'(64'd1 << HUGE_BIT);
            state_q <= S_ACCUM;
          end else begin
            mul_a_q     <= {1'b0, ax_full[HUGE_BIT-1:0]};
            mul_ma_q    <= {1'b0, ax_full[HUGE_BIT-1:0]};
            mul_b_q     <= {1'b0, ay_full[HUGE_BIT-1:0]};
            mul_mb_q    <= {1'b0, ay_full[HUGE_BIT-1:0]};
            state_q     <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_stat.done) begin
            sqrt_rad_q   <= prod;
            state_q      <= S_ROOT1;
          end
        end
        S_ROOT1: begin
          if (sqrt_stat.done) begin
            step_q  <= root;
            state_q <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          travelled_q <= trav_next;
          last_x_q    <= px_q;
          last_y_q    <= py_q;
          state_q     <= S_REM;
        end
        S_REM: begin
          res_cmd_q <= 1'b1;
          res_rem_q <= rem_mm;
          res_vel_q <= '0;
          if (!rem_pos) begin
            if (slow) begin
              mode_q    <= MODE_ACHIEVED;
              res_ach_q <= 1'b1;
            end else begin
              res_ach_q <= 1'b0;
            end
            state_q <= S_PUT;
          end else begin
            res_ach_q   <= 1'b0;
            mul_a_q     <= rem_fx[ddp_pkg::MUL_W-1:0];
            mul_ma_q    <= ddp_pkg::MUL_W'({decel_q, 1'b0});
            mul_b_q     <= '0;
            mul_mb_q    <= '0;
            state_q     <= S_PROD;
          end
        end
        S_PROD: begin
          if (mul_stat.done) begin
            sqrt_rad_q   <= prod << FRAC_BITS;
            state_q      <= S_ROOT2;
          end
        end
        S_ROOT2: begin
          if (sqrt_stat.done) begin
            res_vel_q <= vel;
            state_q   <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_load) begin
            out_cmd_q   <= res_cmd_q;
            out_vel_q   <= res_vel_q;
            out_ach_q   <= res_ach_q;
            out_rem_q   <= res_rem_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.cmd_valid = out_cmd_q;
  assign out_o.cmd_vel   = out_vel_q;
  assign out_o.achieved  = out_ach_q;
  assign out_o.remaining = out_rem_q;

  // ---------------------------------------------------------------------------
  // checks
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_stat.busy && sqrt_stat.busy))
    else $error("multiplier and square root unit busy together");

  a_mul_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> (state_q == S_SQ || state_q == S_PROD))
    else $error("multiplier finished while not awaited");

  a_sqrt_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_stat.done |-> (state_q == S_ROOT1 || state_q == S_ROOT2))
    else $error("square root finished while not awaited");

  a_put_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not moved to output register");

endmodule

@@ rtl/ddp_mul.sv @@
// Bit-serial shift-add multiply-accumulate: prod = a*ma + b*mb, one multiplier bit per cycle.
`timescale 1ns / 1ps

module ddp_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ddp_pkg::MUL_W-1:0]      a_i,
  input  logic [ddp_pkg::MUL_W-1:0]      ma_i,
  input  logic [ddp_pkg::MUL_W-1:0]      b_i,
  input  logic [ddp_pkg::MUL_W-1:0]      mb_i,
  output logic [ddp_pkg::PROD_W-1:0]     prod_o,
  output ddp_pkg::unit_stat_t            stat_o
);

  logic [ddp_pkg::PROD_W-1:0] a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [ddp_pkg::MUL_W-1:0]  ma_q, ma_d, mb_q, mb_d;
  logic [ddp_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [ddp_pkg::PROD_W-1:0] add_a, add_b;

  // one partial product pair per cycle, multiplicands move left, multipliers right
  always_comb begin
    add_a  = ma_q[0] ? a_q : '0;
    add_b  = mb_q[0] ? b_q : '0;
    a_d    = a_q;
    b_d    = b_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = ddp_pkg::PROD_W'(a_i);
      b_d    = ddp_pkg::PROD_W'(b_i);
      ma_d   = ma_i;
      mb_d   = mb_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + add_a + add_b;
      a_d   = a_q << 1;
      b_d   = b_q << 1;
      ma_d  = ma_q >> 1;
      mb_d  = mb_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (&cnt_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
  end

  assign prod_o      = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/ddp_sqrt.sv @@
// Bit-serial integer square root (rounds down), one root bit per cycle.
`timescale 1ns / 1ps

module ddp_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ddp_pkg::PROD_W-1:0]     rad_i,
  output logic [ddp_pkg::ROOT_W-1:0]     root_o,
  output ddp_pkg::unit_stat_t            stat_o
);

  localparam int PREM_W  = ddp_pkg::ROOT_W + 2;   // partial remainder stays below 2*root+1
  localparam int TRIAL_W = PREM_W + 2;

  logic [ddp_pkg::PROD_W-1:0] rad_q, rad_d;
  logic [PREM_W-1:0]          prem_q, prem_d;
  logic [ddp_pkg::ROOT_W-1:0] root_q, root_d;
  logic [ddp_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [TRIAL_W-1:0]         shifted, trial, diff;

  // restoring step: bring down two radicand bits, try subtracting 4*root+1
  always_comb begin
    shifted = {prem_q, rad_q[ddp_pkg::PROD_W-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    diff    = shifted - trial;
    rad_d   = rad_q;
    prem_d  = prem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      prem_d = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      cnt_d = cnt_q + 1'b1;
      if (shifted >= trial) begin
        prem_d = diff[PREM_W-1:0];
        root_d = {root_q[ddp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        prem_d = shifted[PREM_W-1:0];
        root_d = {root_q[ddp_pkg::ROOT_W-2:0], 1'b0};
      end
      if (&cnt_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    prem_q <= prem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the drive-distance braking profile block.
`timescale 1ns / 1ps

module tb_top;

  localparam int POS_W = 24;
  localparam int FRAC_W = 4;
  localparam int STOP_SPEED = 5;
  localparam longint REM_HI = 8388607;
  localparam longint REM_LO = -8388608;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_ITEMS = 50;
  localparam int DRAIN_CYCLES = 200;

  typedef longint unsigned u64_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_GOING    = 2'd1,
    MODE_ACHIEVED = 2'd2
  } mode_e;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_BURSTY} ready_style_e;

  typedef struct {
    ddp_pkg::kind_e                    kind;
    logic signed [POS_W-1:0]           enc_x;
    logic signed [POS_W-1:0]           enc_y;
    logic signed [POS_W-1:0]           odo_x;
    logic signed [POS_W-1:0]           odo_y;
    logic signed [ddp_pkg::VEL_W-1:0]  meas_vel;
  } pose_txn_t;

  typedef struct {
    logic                              cmd_valid;
    logic signed [ddp_pkg::VEL_W-1:0]  cmd_vel;
    logic                              achieved;
    logic signed [ddp_pkg::REM_W-1:0]  remaining;
  } vel_cmd_t;

  // Velocity command predictor plus the queue of commands still owed by the block
  class cmd_scoreboard;
    logic signed [ddp_pkg::TGT_W-1:0]  target;
    logic                              use_enc;
    logic [ddp_pkg::SPEED_W-1:0]       max_speed;
    logic [ddp_pkg::DECEL_W-1:0]       decel;
    mode_e                             mode;
    logic signed [POS_W-1:0]           last_x;
    logic signed [POS_W-1:0]           last_y;
    logic [31:0]                       travelled;
    vel_cmd_t                          expected_cmds[$];
    int unsigned                       mismatches;

    function new();
      target = '0;
      use_enc = 1'b1;
      max_speed = 400;
      decel = 200;
      mode = MODE_IDLE;
      last_x = '0;
      last_y = '0;
      travelled = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [ddp_pkg::CFG_IDX_W-1:0] idx,
                            logic [ddp_pkg::CFG_W-1:0] data);
      case (idx)
        ddp_pkg::CFG_TARGET:    target = data[ddp_pkg::TGT_W-1:0];
        ddp_pkg::CFG_USE_ENC:   use_enc = data[0];
        ddp_pkg::CFG_MAX_SPEED: max_speed = data[ddp_pkg::SPEED_W-1:0];
        ddp_pkg::CFG_DECEL:     decel = data[ddp_pkg::DECEL_W-1:0];
        default: ;
      endcase
    endfunction

    // Floor square root, one result bit per pass from the top
    static function u64_t floor_sqrt(u64_t n);
      u64_t root, trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (u64_t'(1) << b);
        if (trial * trial <= n) root = trial;
      end
      return root;
    endfunction

    function vel_cmd_t predict_cmd(pose_txn_t t);
      vel_cmd_t                          r;
      logic signed [POS_W-1:0]           px, py;
      logic signed [ddp_pkg::VEL_W-1:0]  speed;
      longint                            ddx, ddy, rem, rem_mm;
      u64_t                              dx, dy, stride, sum, mag, v;
      r.cmd_valid = 1'b0;
      r.cmd_vel = '0;
      r.remaining = '0;
      px = use_enc ? t.enc_x : t.odo_x;
      py = use_enc ? t.enc_y : t.odo_y;
      case (t.kind)
        ddp_pkg::KIND_START: begin
          mode = MODE_GOING;
          last_x = px;
          last_y = py;
          travelled = '0;
        end
        ddp_pkg::KIND_CANCEL: mode = MODE_IDLE;
        default: ;
      endcase
      if (t.kind == ddp_pkg::KIND_TICK && mode == MODE_GOING) begin
        // accumulate the Euclidean step in fixed point
        ddx = longint'(px) - longint'(last_x);
        ddy = longint'(py) - longint'(last_y);
        dx = u64_t'(ddx < 0 ? -ddx : ddx) << FRAC_W;
        dy = u64_t'(ddy < 0 ? -ddy : ddy) << FRAC_W;
        if (dx >= (u64_t'(1) << 31) || dy >= (u64_t'(1) << 31))
          stride = u64_t'(1) << 31;
        else
          stride = floor_sqrt(dx * dx + dy * dy);
        sum = u64_t'(travelled) + stride;
        travelled = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        last_x = px;
        last_y = py;

        // remaining distance, floored to mm and saturated
        mag = (target < 0) ? u64_t'(-longint'(target)) : u64_t'(longint'(target));
        rem = longint'(mag << FRAC_W) - longint'(travelled);
        rem_mm = rem >>> FRAC_W;
        if (rem_mm > REM_HI) rem_mm = REM_HI;
        if (rem_mm < REM_LO) rem_mm = REM_LO;
        r.cmd_valid = 1'b1;
        r.remaining = rem_mm[ddp_pkg::REM_W-1:0];

        if (rem <= 0) begin
          if (t.meas_vel > -STOP_SPEED && t.meas_vel < STOP_SPEED) mode = MODE_ACHIEVED;
        end else begin
          v = floor_sqrt((u64_t'(decel) * 2 * u64_t'(rem)) << FRAC_W) >> FRAC_W;
          if (v > max_speed) v = max_speed;
          speed = v[ddp_pkg::VEL_W-1:0];
          r.cmd_vel = (target < 0) ? -speed : speed;
        end
      end
      r.achieved = (mode == MODE_ACHIEVED);
      return r;
    endfunction

    function void note_pose_txn(pose_txn_t t);
      expected_cmds.push_back(predict_cmd(t));
    endfunction

    function int unsigned pending();
      return expected_cmds.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    task check_cmd(vel_cmd_t got);
      vel_cmd_t want;
      if (expected_cmds.size() == 0) begin
        report_mismatch("command transaction with no expectation pending");
        return;
      end
      want = expected_cmds.pop_front();
      if (got.cmd_valid !== want.cmd_valid)
        report_mismatch($sformatf("cmd_valid got %0b want %0b", got.cmd_valid, want.cmd_valid));
      if (got.cmd_vel !== want.cmd_vel)
        report_mismatch($sformatf("cmd_vel got %0d want %0d", got.cmd_vel, want.cmd_vel));
      if (got.achieved !== want.achieved)
        report_mismatch($sformatf("achieved got %0b want %0b", got.achieved, want.achieved));
      if (got.remaining !== want.remaining)
        report_mismatch($sformatf("remaining got %0d want %0d", got.remaining,
                                  want.remaining));
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i;
  logic [ddp_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ddp_pkg::CFG_W-1:0]      cfg_data_i;

  ddp_in_if #(.POS_BITS(POS_W)) in_if ();
  ddp_out_if out_if ();

  drive_distance_decel_profile #(
    .POS_BITS  (POS_W),
    .FRAC_BITS (FRAC_W)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  cmd_scoreboard sb = new();

  ready_style_e  ready_style = READY_ALWAYS;
  int            stall_left = 0;
  bit            sender_idles = 1'b0;
  int            burst_left = 0;
  int            items_sent = 0;
  int unsigned   cycles = 0;

  always #5 clk_i = ~clk_i;

  // Timeout guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Monitors: note accepted pose transactions, check accepted commands
  always @(posedge clk_i) begin : monitors
    pose_txn_t seen_txn;
    vel_cmd_t  seen_cmd;
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_cmd.cmd_valid = out_if.cmd_valid;
      seen_cmd.cmd_vel = out_if.cmd_vel;
      seen_cmd.achieved = out_if.achieved;
      seen_cmd.remaining = out_if.remaining;
      sb.check_cmd(seen_cmd);
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      seen_txn.kind = ddp_pkg::kind_e'(in_if.kind);
      seen_txn.enc_x = in_if.enc_x;
      seen_txn.enc_y = in_if.enc_y;
      seen_txn.odo_x = in_if.odo_x;
      seen_txn.odo_y = in_if.odo_y;
      seen_txn.meas_vel = in_if.measured_vel;
      sb.note_pose_txn(seen_txn);
    end
  end

  // Command sink backpressure
  always @(negedge clk_i) begin
    case (ready_style)
      READY_ALWAYS: out_if.ready <= 1'b1;
      READY_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          out_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 40);
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    endcase
  end

  // Drive one pose transaction, hold it until taken, then maybe pause
  task automatic send_pose(input ddp_pkg::kind_e k,
                           input logic signed [POS_W-1:0] ex, ey, ox, oy,
                           input logic signed [ddp_pkg::VEL_W-1:0] mv);
    int gap;
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.kind <= k;
    in_if.enc_x <= ex;
    in_if.enc_y <= ey;
    in_if.odo_x <= ox;
    in_if.odo_y <= oy;
    in_if.measured_vel <= mv;
    do @(posedge clk_i); while (!in_if.ready);
    if (k != ddp_pkg::KIND_UNUSED) items_sent++;
    if (sender_idles) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 6);
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(input logic [ddp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ddp_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Stop sending and wait until every owed command has been taken
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Reprogram all registers once the block has gone quiet
  task automatic new_phase(input logic signed [ddp_pkg::TGT_W-1:0] tgt, input logic enc,
                           input logic [ddp_pkg::SPEED_W-1:0] spd,
                           input logic [ddp_pkg::DECEL_W-1:0] dec);
    drain_results();
    write_reg(ddp_pkg::CFG_TARGET, tgt);
    write_reg(ddp_pkg::CFG_USE_ENC, ddp_pkg::CFG_W'(enc));
    write_reg(ddp_pkg::CFG_MAX_SPEED, ddp_pkg::CFG_W'(spd));
    write_reg(ddp_pkg::CFG_DECEL, ddp_pkg::CFG_W'(dec));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Start, drive toward the target in random steps, slow down and linger at the end
  task automatic run_approach();
    logic signed [POS_W-1:0]           ex, ey, ox, oy;
    logic signed [ddp_pkg::VEL_W-1:0]  mv;
    longint                            mag, per, moved;
    int                                dir, dx, dy, tail, pick;
    ex = POS_W'($urandom);
    ey = POS_W'($urandom);
    ox = POS_W'(ex + int'($urandom_range(0, 15)));
    oy = ey;
    mag = (sb.target < 0) ? -longint'(sb.target) : longint'(sb.target);
    per = mag / $urandom_range(3, 14) + 1;
    dir = $urandom_range(0, 1) ? 1 : -1;
    moved = 0;
    tail = $urandom_range(1, 3);
    send_pose(ddp_pkg::KIND_START, ex, ey, ox, oy, '0);
    while (tail > 0) begin
      dx = $urandom_range(0, 32'(2 * per));
      dy = $urandom_range(0, 32'(per / 4));
      ex = POS_W'(ex + dir * dx);
      ey = POS_W'(ey + dy);
      ox = POS_W'(ox + dir * dx + int'($urandom_range(0, 2)));
      oy = POS_W'(oy + dy);
      moved += dx;
      if (moved >= mag) begin
        tail--;
        mv = ddp_pkg::VEL_W'(int'($urandom_range(0, 12)) - 6);
      end else begin
        mv = ddp_pkg::VEL_W'($urandom_range(5, 32767));
        if ($urandom_range(0, 3) == 0) mv = -mv;
      end
      // occasional cancel or restart in the middle of the run
      pick = $urandom_range(0, 29);
      if (pick == 0) send_pose(ddp_pkg::KIND_CANCEL, ex, ey, ox, oy, mv);
      else if (pick == 1) send_pose(ddp_pkg::KIND_START, ex, ey, ox, oy, mv);
      else send_pose(ddp_pkg::KIND_TICK, ex, ey, ox, oy, mv);
    end
  endtask

  initial begin
    int phase, phase_start;
    logic signed [ddp_pkg::TGT_W-1:0] tgt;
    in_if.valid = 1'b0;
    in_if.kind = ddp_pkg::KIND_TICK;
    in_if.enc_x = '0;
    in_if.enc_y = '0;
    in_if.odo_x = '0;
    in_if.odo_y = '0;
    in_if.measured_vel = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ddp_pkg::CFG_TARGET;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset register values, zero target, stop-speed boundary
    send_pose(ddp_pkg::KIND_TICK, 0, 0, 0, 0, 0);
    send_pose(ddp_pkg::KIND_UNUSED, -1, -1, -1, -1, -1);
    send_pose(ddp_pkg::KIND_CANCEL, 0, 0, 0, 0, 0);
    send_pose(ddp_pkg::KIND_START, 100, -100, 0, 0, 0);
    send_pose(ddp_pkg::KIND_TICK, 100, -100, 0, 0, 4);
    send_pose(ddp_pkg::KIND_TICK, 100, -100, 0, 0, 0);
    send_pose(ddp_pkg::KIND_START, 100, -100, 0, 0, 0);
    send_pose(ddp_pkg::KIND_TICK, 100, -100, 0, 0, 5);
    send_pose(ddp_pkg::KIND_TICK, 100, -100, 0, 0, -5);
    send_pose(ddp_pkg::KIND_TICK, 100, -100, 0, 0, -4);
    send_pose(ddp_pkg::KIND_CANCEL, 100, -100, 0, 0, 0);

    // Directed: short forward run past the target
    new_phase(1000, 1'b1, 400, 200);
    send_pose(ddp_pkg::KIND_START, 0, 0, 0, 0, 0);
    send_pose(ddp_pkg::KIND_TICK, 3, 4, 0, 0, 300);
    send_pose(ddp_pkg::KIND_TICK, 600, 800, 0, 0, 300);
    send_pose(ddp_pkg::KIND_TICK, 700, 800, 0, 0, 1);

    // Directed: corrected pose, full-scale jumps, saturated remaining distance
    new_phase(-8388608, 1'b0, 32767, 65535);
    send_pose(ddp_pkg::KIND_START, 8388607, 8388607, -8388608, -8388608, 0);
    send_pose(ddp_pkg::KIND_TICK, 8388607, 8388607, -8388600, -8388608, 32767);
    send_pose(ddp_pkg::KIND_TICK, -8388608, -8388608, 8388607, 8388607, -32768);
    send_pose(ddp_pkg::KIND_TICK, 0, 0, -8388608, 8388607, 32767);
    send_pose(ddp_pkg::KIND_START, 0, 0, 0, 0, 0);
    send_pose(ddp_pkg::KIND_TICK, 0, 0, 0, 0, 0);

    // Directed: zero speed cap and zero deceleration
    new_phase(5, 1'b1, 0, 0);
    send_pose(ddp_pkg::KIND_START, 0, 0, 0, 0, 0);
    send_pose(ddp_pkg::KIND_TICK, 1, 1, 0, 0, 100);

    // Random phases: extremes first, then random register settings
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase)
        0: new_phase(8388607, 1'b1, 32767, 65535);
        1: new_phase(-8388608, 1'b0, 0, 0);
        2: new_phase(0, 1'b1, 1, 1);
        default: begin
          tgt = ddp_pkg::TGT_W'(($urandom_range(0, 3) == 0) ? $urandom :
                                $urandom_range(0, 8000) - 4000);
          new_phase(tgt, 1'($urandom_range(0, 1)),
                    ddp_pkg::SPEED_W'(($urandom_range(0, 2) == 0) ? $urandom :
                                      $urandom_range(100, 2000)),
                    ddp_pkg::DECEL_W'(($urandom_range(0, 2) == 0) ? $urandom :
                                      $urandom_range(50, 3000)));
        end
      endcase
      sender_idles = (phase != 0);
      ready_style = (phase == 0) ? READY_ALWAYS : ready_style_e'($urandom_range(0, 2));
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: any kind, any field value
          repeat ($urandom_range(1, 6))
            send_pose(ddp_pkg::kind_e'($urandom_range(0, 3)), POS_W'($urandom),
                      POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                      ddp_pkg::VEL_W'($urandom));
        end else begin
          run_approach();
        end
      end
      phase++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
